// ===== hw/rtl/tpss_pkg.sv =====
// ----------------------------------------------------------------------------
// Tile pipeline slot sequencer package
// Shared types, stage codes and constants.
// ----------------------------------------------------------------------------
package tpss_pkg;

   localparam int MAX_SLOTS_DEF = 8;
   localparam int BUS_BYTES_DEF = 32;

   typedef enum logic [2:0] {
      STG_IDLE  = 3'd0,
      STG_PRE   = 3'd1,
      STG_COMP  = 3'd2,
      STG_STORE = 3'd3,
      STG_DONE  = 3'd4
   } stage_type;

   typedef enum logic [1:0] {
      CSR_SLOTS      = 2'd0,
      CSR_LOAD_OVLP  = 2'd1,
      CSR_STORE_OVLP = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SEARCH,
      SEQ_READ,
      SEQ_STEP,
      SEQ_COUNT,
      SEQ_OUT
   } seq_state_type;

   typedef struct packed {
      logic        req_type;
      logic        has_load;
      logic [31:0] load_bytes;
      logic        has_store;
      logic [31:0] store_bytes;
      logic [31:0] work_cycles;
      logic [7:0]  load_done_mask;
      logic [7:0]  store_done_mask;
   } req_type_t_type;

   typedef struct packed {
      logic        status;
      logic [31:0] tile_number;
      logic [2:0]  slot_taken;
      logic [3:0]  advance_count;
      logic [7:0]  store_start_mask;
      logic [3:0]  free_slot_count;
      logic [3:0]  tiles_in_flight;
      logic [31:0] tiles_finished;
      logic [47:0] saved_cycles;
      logic [47:0] serial_total;
      logic [47:0] piped_total;
      logic [31:0] reject_count;
   } rsp_type;

   // One slot record as kept in the slot memory.
   typedef struct packed {
      logic [47:0] deadline;
      logic [31:0] work;
      logic [31:0] load_beats;
      logic [31:0] store_beats;
      logic        has_load;
      logic        has_store;
   } slot_rec_type;

   // Memory access request from the sequencer.
   typedef struct packed {
      logic         wr_en;
      logic [2:0]   wr_addr;
      slot_rec_type wr_data;
      logic [2:0]   rd_addr;
   } mem_req_type;

endpackage

// ===== hw/rtl/tile_pipeline_slot_sequencer.sv =====
// ----------------------------------------------------------------------------
// Tile pipeline slot sequencer
// One item is worked on at a time: a submit searches the slot stages for a
// free slot and writes its record into the slot memory, and a tick walks the
// slot memory, reading and then stepping each slot in turn.
// Reset (synchronous) idles all slots, clears counters and loads register
// defaults; slot records are undefined until written. No clearing pass.
// ----------------------------------------------------------------------------
module tile_pipeline_slot_sequencer #(
   parameter int MAX_SLOTS = tpss_pkg::MAX_SLOTS_DEF,
   parameter int BUS_BYTES = tpss_pkg::BUS_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tpss_pkg::req_type_t_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tpss_pkg::rsp_type        rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_data
);

   localparam int SW = 3;

   tpss_pkg::seq_state_type state_ff, state_in;
   tpss_pkg::req_type_t_type req_ff;
   tpss_pkg::stage_type stage_ff [8];
   tpss_pkg::stage_type stage_in [8];
   logic [3:0]  slots_cfg_ff;
   logic        lov_ff, sov_ff;
   logic [3:0]  idx_ff, idx_in;
   logic [47:0] cycle_ff, sum_comp_ff, sum_load_ff, sum_store_ff;
   logic [47:0] ov_load_ff, ov_store_ff, serial_ff, stalled_ff;
   logic [31:0] next_num_ff, done_ff, rej_ff;
   logic [3:0]  active_ff;
   logic [3:0]  adv_ff;
   logic [7:0]  smask_ff;
   logic        rsp_valid_ff;
   tpss_pkg::rsp_type rsp_ff;
   tpss_pkg::mem_req_type mem_req;
   tpss_pkg::slot_rec_type rd_data;
   logic [3:0]  n_used;
   logic [31:0] lb, sb;
   logic [47:0] lc, sc;
   logic [3:0]  freec;

   tpss_slot_mem #(.MAX_SLOTS(MAX_SLOTS)) u_mem (
      .clock  (clock),
      .mem_req(mem_req),
      .rd_data(rd_data)
   );

   always_comb begin
      n_used = slots_cfg_ff;
      if (n_used == 4'd0) n_used = 4'd1;
      if (n_used > 4'(MAX_SLOTS)) n_used = 4'(MAX_SLOTS);
      lb = req_ff.load_bytes / BUS_BYTES;
      sb = req_ff.store_bytes / BUS_BYTES;
      lc = req_ff.has_load ? {16'd0, lb} : 48'd1;
      sc = req_ff.has_store ? {16'd0, sb} : 48'd1;
      freec = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < n_used &&
             (stage_ff[i] == tpss_pkg::STG_IDLE || stage_ff[i] == tpss_pkg::STG_DONE))
            freec = freec + 4'd1;
      end
   end

   assign req_stall = (state_ff != tpss_pkg::SEQ_IDLE) || rsp_valid_ff;
   assign csr_ready = (state_ff == tpss_pkg::SEQ_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next state, slot stages, memory address and write for the current step.
   always_comb begin
      mem_req = '0;
      mem_req.rd_addr = idx_ff[SW-1:0];
      mem_req.wr_addr = idx_ff[SW-1:0];
      mem_req.wr_data = rd_data;
      idx_in = idx_ff;
      state_in = state_ff;
      for (int i = 0; i < 8; i++) stage_in[i] = stage_ff[i];
      unique case (state_ff)
         tpss_pkg::SEQ_IDLE: begin
            idx_in = '0;
            if (req_valid && !req_stall)
               state_in = req_data.req_type ? tpss_pkg::SEQ_READ : tpss_pkg::SEQ_SEARCH;
         end
         tpss_pkg::SEQ_SEARCH: begin
            if (idx_ff >= n_used) begin
               state_in = tpss_pkg::SEQ_COUNT;
            end else if (stage_ff[idx_ff[SW-1:0]] == tpss_pkg::STG_IDLE ||
                         stage_ff[idx_ff[SW-1:0]] == tpss_pkg::STG_DONE) begin
               mem_req.wr_en = 1'b1;
               mem_req.wr_data.work = req_ff.work_cycles;
               mem_req.wr_data.load_beats = lb;
               mem_req.wr_data.store_beats = sb;
               mem_req.wr_data.has_load = req_ff.has_load;
               mem_req.wr_data.has_store = req_ff.has_store;
               if (n_used != 4'd1 && lov_ff && done_ff == 32'd0 && !req_ff.has_load) begin
                  stage_in[idx_ff[SW-1:0]] = tpss_pkg::STG_COMP;
                  mem_req.wr_data.deadline = cycle_ff + {16'd0, req_ff.work_cycles};
               end else begin
                  stage_in[idx_ff[SW-1:0]] = tpss_pkg::STG_PRE;
                  mem_req.wr_data.deadline = cycle_ff + lc;
               end
               state_in = tpss_pkg::SEQ_COUNT;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         tpss_pkg::SEQ_READ: begin
            if (idx_ff >= n_used) state_in = tpss_pkg::SEQ_OUT;
            else state_in = tpss_pkg::SEQ_STEP;
         end
         tpss_pkg::SEQ_STEP: begin
            unique case (stage_ff[idx_ff[SW-1:0]])
               tpss_pkg::STG_PRE: begin
                  if (!rd_data.has_load || req_ff.load_done_mask[idx_ff[SW-1:0]]) begin
                     stage_in[idx_ff[SW-1:0]] = tpss_pkg::STG_COMP;
                     mem_req.wr_en = 1'b1;
                     mem_req.wr_data.deadline = cycle_ff + {16'd0, rd_data.work};
                  end
               end
               tpss_pkg::STG_COMP: begin
                  if (cycle_ff >= rd_data.deadline)
                     stage_in[idx_ff[SW-1:0]] = tpss_pkg::STG_STORE;
               end
               tpss_pkg::STG_STORE: begin
                  if (!rd_data.has_store || req_ff.store_done_mask[idx_ff[SW-1:0]])
                     stage_in[idx_ff[SW-1:0]] = tpss_pkg::STG_DONE;
               end
               default: ;
            endcase
            idx_in = idx_ff + 4'd1;
            mem_req.rd_addr = idx_in[SW-1:0];
            state_in = tpss_pkg::SEQ_READ;
         end
         tpss_pkg::SEQ_COUNT: state_in = tpss_pkg::SEQ_OUT;
         tpss_pkg::SEQ_OUT:   state_in = tpss_pkg::SEQ_IDLE;
         default: state_in = tpss_pkg::SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpss_pkg::SEQ_IDLE;
         idx_ff <= '0;
         for (int i = 0; i < 8; i++) stage_ff[i] <= tpss_pkg::STG_IDLE;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         for (int i = 0; i < 8; i++) stage_ff[i] <= stage_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tpss_pkg::SEQ_IDLE && req_valid && !req_stall) req_ff <= req_data;
   end

   // Control registers, counters and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_cfg_ff <= 4'd2;
         lov_ff <= 1'b1;
         sov_ff <= 1'b1;
         cycle_ff <= '0; sum_comp_ff <= '0; sum_load_ff <= '0; sum_store_ff <= '0;
         ov_load_ff <= '0; ov_store_ff <= '0; serial_ff <= '0; stalled_ff <= '0;
         next_num_ff <= '0; done_ff <= '0; rej_ff <= '0; active_ff <= '0;
         adv_ff <= '0; smask_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ff <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tpss_pkg::CSR_SLOTS:      slots_cfg_ff <= csr_data[3:0];
               tpss_pkg::CSR_LOAD_OVLP:  lov_ff <= csr_data[0];
               tpss_pkg::CSR_STORE_OVLP: sov_ff <= csr_data[0];
               default: ;
            endcase
         end
         case (state_ff)
            tpss_pkg::SEQ_IDLE: begin
               // The result register holds until the next input transfer.
               if (req_valid && !req_stall) begin
                  adv_ff <= '0;
                  smask_ff <= '0;
                  rsp_ff <= '0;
                  if (req_data.req_type) cycle_ff <= cycle_ff + 48'd1;
               end
            end
            tpss_pkg::SEQ_SEARCH: begin
               if (idx_ff >= n_used) begin
                  serial_ff <= serial_ff + lc + {16'd0, req_ff.work_cycles} + sc;
                  rej_ff <= rej_ff + 32'd1;
                  stalled_ff <= stalled_ff + {16'd0, req_ff.work_cycles};
                  rsp_ff.status <= 1'b1;
               end else if (stage_ff[idx_ff[SW-1:0]] == tpss_pkg::STG_IDLE ||
                            stage_ff[idx_ff[SW-1:0]] == tpss_pkg::STG_DONE) begin
                  serial_ff <= serial_ff + lc + {16'd0, req_ff.work_cycles} + sc;
                  if (req_ff.has_load) sum_load_ff <= sum_load_ff + {16'd0, lb};
                  if (active_ff < 4'd15) active_ff <= active_ff + 4'd1;
                  rsp_ff.tile_number <= next_num_ff;
                  rsp_ff.slot_taken <= idx_ff[SW-1:0];
                  next_num_ff <= next_num_ff + 32'd1;
               end
            end
            tpss_pkg::SEQ_STEP: begin
               unique case (stage_ff[idx_ff[SW-1:0]])
                  tpss_pkg::STG_PRE: begin
                     if (!rd_data.has_load || req_ff.load_done_mask[idx_ff[SW-1:0]]) begin
                        sum_comp_ff <= sum_comp_ff + {16'd0, rd_data.work};
                        if (active_ff >= 4'd2 && lov_ff && rd_data.has_load)
                           ov_load_ff <= ov_load_ff + {16'd0, rd_data.load_beats};
                        adv_ff <= adv_ff + 4'd1;
                     end
                  end
                  tpss_pkg::STG_COMP: begin
                     if (cycle_ff >= rd_data.deadline) begin
                        if (rd_data.has_store) begin
                           smask_ff[idx_ff[SW-1:0]] <= 1'b1;
                           sum_store_ff <= sum_store_ff + {16'd0, rd_data.store_beats};
                        end
                        adv_ff <= adv_ff + 4'd1;
                     end
                  end
                  tpss_pkg::STG_STORE: begin
                     if (!rd_data.has_store || req_ff.store_done_mask[idx_ff[SW-1:0]]) begin
                        if (active_ff > 4'd0) active_ff <= active_ff - 4'd1;
                        done_ff <= done_ff + 32'd1;
                        if (active_ff >= 4'd2 && sov_ff && rd_data.has_store)
                           ov_store_ff <= ov_store_ff + {16'd0, rd_data.store_beats};
                        adv_ff <= adv_ff + 4'd1;
                     end
                  end
                  default: ;
               endcase
            end
            tpss_pkg::SEQ_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.advance_count <= adv_ff;
               rsp_ff.store_start_mask <= smask_ff;
               rsp_ff.free_slot_count <= freec;
               rsp_ff.tiles_in_flight <= active_ff;
               rsp_ff.tiles_finished <= done_ff;
               rsp_ff.saved_cycles <= ov_load_ff + ov_store_ff;
               rsp_ff.serial_total <= serial_ff;
               rsp_ff.piped_total <= sum_comp_ff + (sum_load_ff - ov_load_ff)
                                     + (sum_store_ff - ov_store_ff);
               rsp_ff.reject_count <= rej_ff;
            end
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tpss_pkg::SEQ_IDLE) |-> req_stall)
      else $error("input taken while busy");
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpss_pkg::SEQ_OUT) |=> rsp_valid)
      else $error("result not raised");
   a_idle_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpss_pkg::SEQ_OUT) |=> (state_ff == tpss_pkg::SEQ_IDLE))
      else $error("sequencer did not return to idle");
`endif

endmodule

// ===== hw/rtl/tpss_slot_mem.sv =====
// ----------------------------------------------------------------------------
// Slot record memory
// Synchronous memory of slot records, one write and one registered read.
// ----------------------------------------------------------------------------
module tpss_slot_mem #(
   parameter int MAX_SLOTS = tpss_pkg::MAX_SLOTS_DEF
) (
   input  logic                  clock,
   input  tpss_pkg::mem_req_type mem_req,
   output tpss_pkg::slot_rec_type rd_data
);

   tpss_pkg::slot_rec_type mem_ff [MAX_SLOTS];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data <= mem_ff[mem_req.rd_addr];
   end

endmodule
